@@ sv/grid_ring_pattern_finder_assert.svh @@
// Assertion macros for the grid ring pattern finder.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef GRID_RING_PATTERN_FINDER_ASSERT_SVH
`define GRID_RING_PATTERN_FINDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GRP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grp assertion failed");
`define GRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grp assertion failed");
`else
`define GRP_ASSERT_IMPL(label, ante, cons)
`define GRP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/grp_pkg.sv @@
package grp_pkg;

  localparam int CNT_W   = 11;
  localparam int VAL_W   = 32;
  localparam int CLS_W   = 2;
  localparam int LINES_W = 2 * CLS_W;
  localparam int CFG_IDX_W = 2;

  localparam int CLS_BORDER_BIT = 0;
  localparam int CLS_CENTER_BIT = 1;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST    = 11'd3;
  localparam logic [CNT_W-1:0] COL_COUNT_RST    = 11'd3;
  localparam logic [VAL_W-1:0] BORDER_VALUE_RST = 32'd7;
  localparam logic [VAL_W-1:0] CENTER_VALUE_RST = 32'd42;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COL_COUNT    = 2'd1,
    CFG_BORDER_VALUE = 2'd2,
    CFG_CENTER_VALUE = 2'd3
  } cfg_idx_t;

  // cell in flight between the line-buffer read and the window update
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               fwd;
    logic [LINES_W-1:0] fwd_lines;
    logic [CNT_W-1:0]   row;
    logic [CNT_W-1:0]   col;
    logic [CLS_W-1:0]   cls;
  } s2_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } result_t;

endpackage

@@ sv/grp_if.sv @@
interface grp_cell_if;
  import grp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface grp_result_if;
  import grp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] found_row;
  logic [CNT_W-1:0] found_col;

  modport source (output valid, output found_row, output found_col, input ready);
  modport sink (input valid, input found_row, input found_col, output ready);
endinterface

@@ sv/grid_ring_pattern_finder.sv @@
// Grid ring pattern finder: 3x3 window template match over a raster grid.
// Cells arrive on in_ch, one per transfer, row by row. Each cell is reduced to
// a border/centre class; a single line-buffer RAM holds the classes of the two
// previous rows and a 3x3 class window slides along the current row.
// After the last cell of a row_count x col_count grid one result goes out on
// out_ch: 1-based row and column of the window centre of the leftmost match in
// the bottom-most matching row, or 0/0 when nothing matched.
// Throughput: one cell per clock; each cell costs one read and one write of
// the line-buffer RAM, whose single read and write port set that figure.
// Result path: the RAM read is taken at the transfer of the last cell, then the
// window update goes into the output register.
// Stall: the output register holds a result until out_ch takes it; ordinary
// cells keep flowing, only the last cell of a grid waits for a free register,
// so one right behind another last cell waits until out_ch takes that result.
// Reset: registers take their defaults (3 x 3 grid, border 7, centre 42) and
// the position returns to the grid origin; the line buffer is not cleared.
// Configuration via cfg_we/cfg_index/cfg_wdata, only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
module grid_ring_pattern_finder #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  grp_cell_if.sink                      in_ch,
  grp_result_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [grp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grp_pkg::VAL_W-1:0]     cfg_wdata
);
  import grp_pkg::*;

  `include "grid_ring_pattern_finder_assert.svh"

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CCMP_W = ((CW > CNT_W) ? CW : CNT_W) + 1;
  localparam int RCMP_W = ((RW > CNT_W) ? RW : CNT_W) + 1;

  logic [CNT_W-1:0]   row_count_r;
  logic [CNT_W-1:0]   col_count_r;
  logic [VAL_W-1:0]   border_value_r;
  logic [VAL_W-1:0]   center_value_r;

  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  s2_t                s2_r, s2_nxt;
  logic [CW-1:0]      s2_addr_r;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   out_row_r;
  logic [CNT_W-1:0]   out_col_r;

  logic               last_col;
  logic               last_row;
  logic               is_last;
  logic               last_ok;
  logic               in_fire;
  logic [CLS_W-1:0]   cls;
  logic [LINES_W-1:0] ram_rdata;
  logic [LINES_W-1:0] m_wdata;
  result_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      col_count_r    <= COL_COUNT_RST;
      border_value_r <= BORDER_VALUE_RST;
      center_value_r <= CENTER_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_COUNT:    row_count_r    <= cfg_wdata[CNT_W-1:0];
        CFG_COL_COUNT:    col_count_r    <= cfg_wdata[CNT_W-1:0];
        CFG_BORDER_VALUE: border_value_r <= cfg_wdata;
        CFG_CENTER_VALUE: center_value_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    // a count of zero acts as one; counts above the maximum act as the maximum
    last_col = (col_count_r == '0)
               || (CCMP_W'(col_r) + CCMP_W'(1) >= CCMP_W'(col_count_r))
               || (CCMP_W'(col_r) + CCMP_W'(1) >= CCMP_W'(MAX_COLS));
    last_row = (row_count_r == '0)
               || (RCMP_W'(row_r) + RCMP_W'(1) >= RCMP_W'(row_count_r))
               || (RCMP_W'(row_r) + RCMP_W'(1) >= RCMP_W'(MAX_ROWS));
    is_last  = last_col && last_row;

    // hold the last cell until the output register is sure to be free
    last_ok     = !(s2_r.valid && s2_r.last) && (!out_valid_r || out_ch.ready);
    in_ch.ready = !is_last || last_ok;
    in_fire     = in_ch.valid && in_ch.ready;

    cls = '0;
    cls[CLS_BORDER_BIT] = (in_ch.cell_value == border_value_r);
    cls[CLS_CENTER_BIT] = (in_ch.cell_value == center_value_r);

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    s2_nxt.valid     = in_fire;
    s2_nxt.last      = is_last;
    // the write of the previous cell lands at the edge this read is taken
    s2_nxt.fwd       = s2_r.valid && (s2_addr_r == col_r);
    s2_nxt.fwd_lines = m_wdata;
    s2_nxt.row       = CNT_W'(row_r);
    s2_nxt.col       = CNT_W'(col_r);
    s2_nxt.cls       = cls;

    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s2_r        <= s2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_addr_r <= col_r;
    end
    if (res.valid) begin
      out_row_r <= res.row;
      out_col_r <= res.col;
    end
  end

  grp_ram #(
    .WIDTH (LINES_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .we      (s2_r.valid),
    .waddr   (s2_addr_r),
    .wdata   (m_wdata),
    .re      (in_fire),
    .raddr   (col_r),
    .rdata_r (ram_rdata)
  );

  grp_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .s2    (s2_r),
    .rdata (ram_rdata),
    .wdata (m_wdata),
    .res   (res)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.found_row = out_row_r;
  assign out_ch.found_col = out_col_r;

  `GRP_ASSERT_IMPL(a_no_result_overwrite, res.valid, !out_valid_r || out_ch.ready)
  `GRP_ASSERT_NEXT(a_last_cell_gives_result, in_fire && is_last, res.valid)
  `GRP_ASSERT_IMPL(a_match_centre_inside,
                   res.valid && (res.row != '0),
                   (res.row >= CNT_W'(2)) && (res.col >= CNT_W'(2)))

endmodule

@@ sv/grp_ram.sv @@
module grp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write of the same entry at one edge return old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ sv/grp_match.sv @@
module grp_match (
  input  logic                        clk,
  input  logic                        rst_n,
  input  grp_pkg::s2_t                s2,
  input  logic [grp_pkg::LINES_W-1:0] rdata,
  output logic [grp_pkg::LINES_W-1:0] wdata,
  output grp_pkg::result_t            res
);
  import grp_pkg::*;

  logic [CLS_W-1:0]   win_r   [9];
  logic [CLS_W-1:0]   win_nxt [9];
  logic [CNT_W-1:0]   match_row_r, match_row_nxt;
  logic [CNT_W-1:0]   match_col_r, match_col_nxt;
  logic [LINES_W-1:0] lines;
  logic               window_ok;
  logic               hit;
  logic [CNT_W-1:0]   mrow;
  logic [CNT_W-1:0]   mcol;

  always_comb begin
    lines = s2.fwd ? s2.fwd_lines : rdata;
    win_nxt = win_r;
    if (s2.valid) begin
      // shift left one column, new column enters on the right
      for (int k = 0; k < 3; k++) begin
        win_nxt[k*3]   = win_r[k*3+1];
        win_nxt[k*3+1] = win_r[k*3+2];
      end
      win_nxt[2] = lines[LINES_W-1:CLS_W];
      win_nxt[5] = lines[CLS_W-1:0];
      win_nxt[8] = s2.cls;
    end

    window_ok = win_nxt[4][CLS_CENTER_BIT];
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        window_ok = window_ok && win_nxt[k][CLS_BORDER_BIT];
      end
    end

    // one match per row: the leftmost wins, a later row replaces it
    hit = s2.valid && (s2.row >= CNT_W'(2)) && (s2.col >= CNT_W'(2))
          && (match_row_r != s2.row) && window_ok;
    mrow = hit ? s2.row : match_row_r;
    mcol = hit ? s2.col : match_col_r;

    res.valid = s2.valid && s2.last;
    res.row   = mrow;
    res.col   = mcol;

    match_row_nxt = res.valid ? '0 : mrow;
    match_col_nxt = res.valid ? '0 : mcol;

    wdata = {lines[CLS_W-1:0], s2.cls};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
      match_row_r <= '0;
      match_col_r <= '0;
    end else begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
      match_row_r <= match_row_nxt;
      match_col_r <= match_col_nxt;
    end
  end

endmodule
